// File: rtl/d2mjd_pkg.sv
// Package for the date to Modified Julian Day converter.
// Holds field widths, calendar constants and the month tables.
// No dependencies.
package d2mjd_pkg;

  localparam int YearW = 12;
  localparam int MonthW = 4;
  localparam int DayW = 5;
  localparam int MjdW = 20;
  localparam int DoyW = 9;

  localparam logic [YearW-1:0] FirstYear = 12'd2006;
  localparam int MjdBaseInt = 53735;
  localparam int LeapsBeforeFirst = 486;
  localparam logic [MjdW-1:0] MjdOffset = MjdW'(MjdBaseInt - LeapsBeforeFirst);
  localparam logic [8:0] DaysPerYear = 9'd365;
  localparam logic [DayW-1:0] FebLeapLen = 5'd29;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] d;
    unique case (m)
      4'd2: d = 9'd31;
      4'd3: d = 9'd59;
      4'd4: d = 9'd90;
      4'd5: d = 9'd120;
      4'd6: d = 9'd151;
      4'd7: d = 9'd181;
      4'd8: d = 9'd212;
      4'd9: d = 9'd243;
      4'd10: d = 9'd273;
      4'd11: d = 9'd304;
      4'd12: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Quotient by 25 through the reciprocal 41/1024, exact for inputs below 1024.
  function automatic logic [5:0] div25(input logic [9:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd41;
    return p[15:10];
  endfunction

endpackage

// File: rtl/date_to_modified_julian_day.sv
// Top level of the Gregorian date to Modified Julian Day converter.
// Depends on d2mjd_pkg for widths, constants, month tables and div25.
//
// Each request carries a year, month and day and gives one result: the Modified
// Julian Day number and a valid flag, with the number forced to zero for an
// invalid date. A request is registered on entry and the conversion is combinational
// between that register and the result register, so one date is taken every cycle
// while the result side accepts results. Both registers hold while the result side
// stalls.
module date_to_modified_julian_day
  import d2mjd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [YearW-1:0]  in_year,
  input  logic [MonthW-1:0] in_month,
  input  logic [DayW-1:0]   in_day,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MjdW-1:0]   out_day_number,
  output logic              out_date_valid
);

  logic              s1_valid_r;
  logic [YearW-1:0]  year_r;
  logic [MonthW-1:0] month_r;
  logic [DayW-1:0]   day_r;
  logic              out_valid_r;
  logic [MjdW-1:0]   day_number_r;
  logic              date_valid_r;

  logic              out_free;
  logic              s1_adv;

  logic              leap;
  logic [DayW-1:0]   mlen;
  logic              valid_nxt;
  logic [DoyW-1:0]   doy;
  logic [YearW-1:0]  yrs;
  logic [YearW-1:0]  prev;
  logic [9:0]        q4;
  logic [5:0]        q100;
  logic [5:0]        q400;
  logic [9:0]        extra;
  logic [5:0]        y_q100;
  logic [5:0]        y_q400;
  logic              y_div100;
  logic              y_div400;
  logic [20:0]       yr_days;
  logic [MjdW-1:0]   day_number_nxt;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_comb begin
    y_q100 = div25(year_r[11:2]);
    y_q400 = div25({2'b00, year_r[11:4]});
    y_div100 = (year_r[1:0] == 2'b00) && (10'(y_q100) * 10'd25 == year_r[11:2]);
    y_div400 = (year_r[3:0] == 4'b0000) &&
               (10'(y_q400) * 10'd25 == {2'b00, year_r[11:4]});
    leap = ((year_r[1:0] == 2'b00) && !y_div100) || y_div400;

    mlen = month_len(month_r);
    if ((month_r == MonthFeb) && leap) begin
      mlen = FebLeapLen;
    end
    valid_nxt = (year_r >= FirstYear) && (month_r != '0) && (month_r <= MonthDec) &&
                (day_r != '0) && (day_r <= mlen);

    doy = days_before(month_r) + DoyW'(day_r) +
          DoyW'((leap && (month_r > MonthFeb)) ? 1 : 0);
    yrs = year_r - FirstYear;
    prev = year_r - 12'd1;
    q4 = prev[11:2];
    q100 = div25(prev[11:2]);
    q400 = div25({2'b00, prev[11:4]});
    extra = q4 - 10'(q100) + 10'(q400);
    yr_days = 21'(yrs) * 21'(DaysPerYear);

    day_number_nxt = '0;
    if (valid_nxt) begin
      day_number_nxt = MjdOffset + MjdW'(doy) + yr_days[MjdW-1:0] + MjdW'(extra);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      year_r <= in_year;
      month_r <= in_month;
      day_r <= in_day;
    end
    if (s1_adv) begin
      day_number_r <= day_number_nxt;
      date_valid_r <= valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_day_number = day_number_r;
  assign out_date_valid = date_valid_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !date_valid_r) |-> (day_number_r == '0))
    else $error("invalid date gave a nonzero day number");

  a_valid_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && date_valid_r) |-> (day_number_r > MjdW'(MjdBaseInt)))
    else $error("valid date below the first day");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted request lost at the input register");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced request lost at the result register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && s1_valid_r) |-> !in_ready)
    else $error("request taken while both registers are full and stalled");

endmodule

// File: test/date_to_modified_julian_day_tb.sv
// Self-checking testbench for date_to_modified_julian_day: directed and random dates
// go through the valid/ready request channel, and each result is checked against a
// calendar predictor. Depends on d2mjd_pkg for field widths and calendar constants.
module date_to_modified_julian_day_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import d2mjd_pkg::*;

  typedef struct {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct {
    logic [MjdW-1:0] day_number;
    logic            date_valid;
  } mjd_t;

  localparam int RandomPerPhase = 160;
  localparam int NumPhases = 4;
  localparam int SendIdlePct [NumPhases] = '{0, 75, 0, 22};
  localparam int RecvStallPct [NumPhases] = '{0, 0, 75, 22};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [YearW-1:0]  in_year = '0;
  logic [MonthW-1:0] in_month = '0;
  logic [DayW-1:0]   in_day = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MjdW-1:0]   out_day_number;
  logic              out_date_valid;

  date_t pending_dates [$];
  mjd_t  expected_days [$];
  date_t next_date;
  mjd_t  want;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    mismatch_count = 0;

  date_to_modified_julian_day i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_day_number (out_day_number),
    .out_date_valid (out_date_valid)
  );

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11: return 30;
      2: return leap_year(y) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned leap_count(int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic mjd_t convert_date(logic [YearW-1:0] year, logic [MonthW-1:0] month,
                                        logic [DayW-1:0] day);
    mjd_t        r;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned day_of_year;
    y = year;
    m = month;
    d = day;
    r.day_number = '0;
    r.date_valid = 1'b0;
    if (y >= FirstYear && d >= 1 && d <= days_in_month(y, m)) begin
      day_of_year = d;
      for (int unsigned k = 1; k < m; k++) day_of_year += days_in_month(y, k);
      r.day_number = MjdW'(MjdBaseInt + day_of_year + 365 * (y - FirstYear)
                           + leap_count(y - 1) - leap_count(FirstYear - 1));
      r.date_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic date_t make_date(int unsigned y, int unsigned m, int unsigned d);
    date_t r;
    r.year = YearW'(y);
    r.month = MonthW'(m);
    r.day = DayW'(d);
    return r;
  endfunction

  function automatic date_t random_date();
    int unsigned edge_years [12] = '{2006, 2007, 2008, 2048, 2100, 2104, 2400, 2800, 3200,
                                     4000, 4094, 4095};
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    pick = $urandom_range(99);
    if ($urandom_range(3) == 0) y = edge_years[$urandom_range(11)];
    else y = $urandom_range(4095, FirstYear);
    m = $urandom_range(12, 1);
    len = days_in_month(y, m);
    if (pick < 70) begin
      return make_date(y, m, $urandom_range(len, 1));
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0: return make_date($urandom_range(FirstYear - 1, 0), m, $urandom_range(len, 1));
        1: return make_date(y, ($urandom_range(1) == 0) ? 0 : $urandom_range(15, 13),
                            $urandom_range(31, 1));
        2: return make_date(y, m, 0);
        default: return make_date(y, m, (len < 31) ? len + 1 : 0);
      endcase
    end
    return make_date($urandom_range(4095), $urandom_range(15), $urandom_range(31));
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (!(pending_dates.size() == 0 && !in_valid && expected_days.size() == 0));
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_days.push_back(convert_date(in_year, in_month, in_day));
      if (pending_dates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_date = pending_dates.pop_front();
        in_year  <= next_date.year;
        in_month <= next_date.month;
        in_day   <= next_date.day;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_days.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_days.pop_front();
          if (out_day_number !== want.day_number)
            report_mismatch($sformatf("day_number %0d, expected %0d",
                                      out_day_number, want.day_number));
          if (out_date_valid !== want.date_valid)
            report_mismatch($sformatf("date_valid %0b, expected %0b",
                                      out_date_valid, want.date_valid));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    pending_dates.push_back(make_date(2006, 1, 1));
    pending_dates.push_back(make_date(4095, 12, 31));
    pending_dates.push_back(make_date(0, 0, 0));
    pending_dates.push_back(make_date(4095, 15, 31));
    pending_dates.push_back(make_date(2005, 12, 31));
    pending_dates.push_back(make_date(2008, 2, 29));
    pending_dates.push_back(make_date(2007, 2, 29));
    pending_dates.push_back(make_date(2100, 2, 29));
    pending_dates.push_back(make_date(2100, 2, 28));
    pending_dates.push_back(make_date(2400, 2, 29));
    pending_dates.push_back(make_date(2024, 3, 1));
    pending_dates.push_back(make_date(2023, 3, 1));
    pending_dates.push_back(make_date(2006, 4, 30));
    pending_dates.push_back(make_date(2006, 4, 31));
    pending_dates.push_back(make_date(2006, 11, 31));
    pending_dates.push_back(make_date(2006, 0, 1));
    pending_dates.push_back(make_date(2006, 13, 1));
    pending_dates.push_back(make_date(2006, 1, 0));
    pending_dates.push_back(make_date(2006, 12, 31));
    pending_dates.push_back(make_date(2007, 1, 1));
    pending_dates.push_back(make_date(4000, 12, 31));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct = SendIdlePct[p];
      recv_stall_pct = RecvStallPct[p];
      for (int i = 0; i < RandomPerPhase; i++) pending_dates.push_back(random_date());
      wait_drained();
    end
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_days.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
